@@ sv/arrs_pkg.sv @@
// Shared types and constants for the affinity round-robin scheduler.
`timescale 1ns / 1ps
`default_nettype none

package arrs_pkg;

  // Input word kinds
  localparam logic KIND_SUBMIT = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_TICK    = 2'd0;
  localparam logic [1:0] ST_ACCEPT  = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_AFF = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_CPU_COUNT = 3'd0;
  localparam logic [2:0] REG_QUANTUM_0 = 3'd1;
  localparam logic [2:0] REG_QUANTUM_1 = 3'd2;
  localparam logic [2:0] REG_QUANTUM_2 = 3'd3;
  localparam logic [2:0] REG_QUANTUM_3 = 3'd4;

  // Reset values
  localparam logic [2:0]  CPU_COUNT_RESET = 3'd4;
  localparam logic [15:0] QUANTUM_RESET   = 16'd4;
  localparam logic [15:0] SLICE_RESET     = 16'd4;
  localparam logic [15:0] TIME_RESET      = 16'd1;

  typedef struct packed {
    logic        kind;
    logic [7:0]  job_id;
    logic [15:0] arrival_time;
    logic [15:0] duration;
    logic [1:0]  affinity;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  cpu_index;
    logic        running;
    logic [7:0]  run_job;
    logic        finished;
    logic [15:0] tick_time;
    logic        all_done;
    logic        last;
  } out_word_t;

  // Pending list entry
  typedef struct packed {
    logic [7:0]  job_id;
    logic [15:0] arrival_time;
    logic [15:0] duration;
    logic [1:0]  affinity;
  } pend_t;

  // Run queue entry
  typedef struct packed {
    logic [7:0]  job_id;
    logic [15:0] left;
  } qent_t;

  typedef struct packed {
    logic take;
    logic scan_start;
    logic submit;
    logic scan_step;
    logic scan_fin;
    logic run_wb;
    logic emit_sub;
    logic emit_tick;
    logic tick_end;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_busy;
    logic run_last;
    logic emit_last;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ sv/arrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module arrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ sv/arrs_ctrl.sv @@
// Sequencer for submit and tick handling.
`timescale 1ns / 1ps
`default_nettype none

module arrs_ctrl import arrs_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    in_kind,
  output logic         in_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_SUB_OUT,
    S_SCAN,
    S_RUN_RD,
    S_RUN_WB,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_kind == KIND_TICK) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end else begin
            state_nxt = S_SUB;
          end
        end
      end
      S_SUB: begin
        cmd.submit = 1'b1;
        state_nxt  = S_SUB_OUT;
      end
      S_SUB_OUT: begin
        if (sts.out_free) begin
          cmd.emit_sub = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_SCAN: begin
        if (sts.scan_busy) begin
          cmd.scan_step = 1'b1;
        end else begin
          cmd.scan_fin = 1'b1;
          state_nxt    = S_RUN_RD;
        end
      end
      // queue head read is in flight
      S_RUN_RD: begin
        state_nxt = S_RUN_WB;
      end
      S_RUN_WB: begin
        cmd.run_wb = 1'b1;
        state_nxt  = sts.run_last ? S_EMIT : S_RUN_RD;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_tick = 1'b1;
          if (sts.emit_last) begin
            cmd.tick_end = 1'b1;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/arrs_dp.sv @@
// Datapath: config registers, pending list, per-CPU run queues, result register.
`timescale 1ns / 1ps
`default_nettype none

module arrs_dp import arrs_pkg::*; #(
  parameter int NUM_CPUS = 4,
  parameter int MAX_JOBS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire dp_cmd_t     cmd,
  output dp_sts_t          sts,
  input  wire in_word_t    in_data,
  input  wire logic        cfg_valid,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output out_word_t        out_data
);

  localparam int CPU_SLOTS = (NUM_CPUS < 4) ? NUM_CPUS : 4;
  localparam int CIW       = (CPU_SLOTS > 1) ? $clog2(CPU_SLOTS) : 1;
  localparam int SW        = $clog2(MAX_JOBS);
  localparam int CW        = $clog2(MAX_JOBS + 1);
  localparam int QDEPTH    = CPU_SLOTS * (1 << SW);
  localparam int QAW       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int PW        = $bits(pend_t);
  localparam int QW        = $bits(qent_t);

  function automatic logic [SW-1:0] slot_wrap(input logic [SW-1:0] h,
                                              input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - SW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(MAX_JOBS)) s = s - (CW + 1)'(MAX_JOBS);
    return s[SW-1:0];
  endfunction

  function automatic logic [QAW-1:0] qaddr(input logic [CIW-1:0] cpu,
                                           input logic [SW-1:0] slot);
    logic [SW+1:0] full;
    full = {2'(cpu), slot};
    return full[QAW-1:0];
  endfunction

  in_word_t      item_r;
  logic [2:0]    cpu_count_r;
  logic [15:0]   quantum_r [4];
  logic [15:0]   time_r;
  logic [CW-1:0] job_total_r;
  logic [CW-1:0] pcnt_r;
  logic [CW-1:0] rd_idx_r;
  logic [CW-1:0] k_r;
  logic          eval_v_r;
  logic [SW-1:0] qhead_r [CPU_SLOTS];
  logic [CW-1:0] qcnt_r  [CPU_SLOTS];
  logic [15:0]   slice_r [CPU_SLOTS];
  logic [CIW-1:0] c_r;
  logic [CIW-1:0] e_r;
  logic          rep_run_r [CPU_SLOTS];
  logic [7:0]    rep_job_r [CPU_SLOTS];
  logic          rep_fin_r [CPU_SLOTS];
  logic [1:0]    sub_status_r;
  logic          out_valid_r;
  out_word_t     out_data_r;

  logic [2:0]    n_act;
  logic [2:0]    n_last;

  // memory ports
  logic            pend_we;
  logic [SW-1:0]   pend_waddr;
  pend_t           pend_wdata;
  logic [PW-1:0]   pend_rdata;
  logic            q_we;
  logic [QAW-1:0]  q_waddr;
  qent_t           q_wdata;
  logic [QW-1:0]   q_rdata;

  // scan eval
  pend_t           pe;
  logic            pe_match;
  logic [CIW-1:0]  pe_cpu;

  // run step
  qent_t           qe;
  logic [CW-1:0]   cur_cnt;
  logic [SW-1:0]   cur_head;
  logic [15:0]     cur_sl;
  logic [15:0]     left_nxt;
  logic [15:0]     sl_dec;
  logic            has_job;
  logic            fin_c;
  logic            rot_c;
  logic [SW-1:0]   head_nxt;
  logic [SW-1:0]   tail_slot;
  logic [15:0]     eff_q;
  logic [1:0]      sub_status_nxt;

  always_comb begin
    if (cpu_count_r == 3'd0) begin
      n_act = 3'd1;
    end else if (cpu_count_r > 3'(CPU_SLOTS)) begin
      n_act = 3'(CPU_SLOTS);
    end else begin
      n_act = cpu_count_r;
    end
  end
  assign n_last = n_act - 3'd1;

  assign pe       = pend_t'(pend_rdata);
  assign pe_match = (pe.arrival_time == time_r);
  assign pe_cpu   = pe.affinity[CIW-1:0];

  assign qe        = qent_t'(q_rdata);
  assign cur_cnt   = qcnt_r[c_r];
  assign cur_head  = qhead_r[c_r];
  assign cur_sl    = slice_r[c_r];
  assign left_nxt  = (qe.left != 16'd0) ? qe.left - 16'd1 : 16'd0;
  assign sl_dec    = (cur_sl != 16'd0) ? cur_sl - 16'd1 : 16'd0;
  assign has_job   = (cur_cnt != '0);
  assign fin_c     = has_job && (left_nxt == 16'd0);
  assign rot_c     = has_job && !fin_c && (sl_dec == 16'd0);
  assign head_nxt  = slot_wrap(cur_head, CW'(1));
  assign tail_slot = slot_wrap(cur_head, cur_cnt);
  assign eff_q     = (quantum_r[2'(c_r)] == 16'd0) ? 16'd1 : quantum_r[2'(c_r)];

  always_comb begin
    if ({1'b0, item_r.affinity} >= n_act) begin
      sub_status_nxt = ST_BAD_AFF;
    end else if (job_total_r >= CW'(MAX_JOBS)) begin
      sub_status_nxt = ST_FULL;
    end else begin
      sub_status_nxt = ST_ACCEPT;
    end
  end

  always_comb begin
    pend_we    = 1'b0;
    pend_waddr = k_r[SW-1:0];
    pend_wdata = pe;
    if (cmd.submit) begin
      pend_we    = (sub_status_nxt == ST_ACCEPT);
      pend_waddr = pcnt_r[SW-1:0];
      pend_wdata = '{job_id: item_r.job_id, arrival_time: item_r.arrival_time,
                     duration: item_r.duration, affinity: item_r.affinity};
    end else if (cmd.scan_step && eval_v_r && !pe_match) begin
      pend_we = 1'b1;
    end
  end

  always_comb begin
    q_we    = 1'b0;
    q_waddr = qaddr(pe_cpu, slot_wrap(qhead_r[pe_cpu], qcnt_r[pe_cpu]));
    q_wdata = '{job_id: pe.job_id, left: pe.duration};
    if (cmd.scan_step && eval_v_r && pe_match) begin
      q_we = 1'b1;
    end else if (cmd.run_wb && has_job && !fin_c) begin
      q_we    = 1'b1;
      q_waddr = qaddr(c_r, rot_c ? tail_slot : cur_head);
      q_wdata = '{job_id: qe.job_id, left: left_nxt};
    end
  end

  arrs_ram #(.WIDTH(PW), .DEPTH(MAX_JOBS)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (rd_idx_r[SW-1:0]),
    .rdata (pend_rdata)
  );

  arrs_ram #(.WIDTH(QW), .DEPTH(QDEPTH)) u_queue_ram (
    .clk   (clk),
    .we    (q_we),
    .waddr (q_waddr),
    .wdata (q_wdata),
    .raddr (qaddr(c_r, cur_head)),
    .rdata (q_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpu_count_r <= CPU_COUNT_RESET;
      for (int i = 0; i < 4; i++) quantum_r[i] <= QUANTUM_RESET;
      time_r      <= TIME_RESET;
      job_total_r <= '0;
      pcnt_r      <= '0;
      rd_idx_r    <= '0;
      k_r         <= '0;
      eval_v_r    <= 1'b0;
      c_r         <= '0;
      e_r         <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CPU_SLOTS; i++) begin
        qhead_r[i] <= '0;
        qcnt_r[i]  <= '0;
        slice_r[i] <= SLICE_RESET;
      end
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_CPU_COUNT: cpu_count_r  <= cfg_data[2:0];
          REG_QUANTUM_0: quantum_r[0] <= cfg_data;
          REG_QUANTUM_1: quantum_r[1] <= cfg_data;
          REG_QUANTUM_2: quantum_r[2] <= cfg_data;
          REG_QUANTUM_3: quantum_r[3] <= cfg_data;
          default: ;
        endcase
      end

      if (cmd.take) begin
        item_r <= in_data;
      end

      if (cmd.scan_start) begin
        rd_idx_r <= '0;
        k_r      <= '0;
        eval_v_r <= 1'b0;
        c_r      <= '0;
        e_r      <= '0;
      end

      if (cmd.submit) begin
        sub_status_r <= sub_status_nxt;
        if (sub_status_nxt == ST_ACCEPT) begin
          pcnt_r      <= pcnt_r + CW'(1);
          job_total_r <= job_total_r + CW'(1);
        end
      end

      // read of entry i overlaps the evaluation of entry i-1
      if (cmd.scan_step) begin
        eval_v_r <= (rd_idx_r < pcnt_r);
        if (rd_idx_r < pcnt_r) rd_idx_r <= rd_idx_r + CW'(1);
        if (eval_v_r) begin
          if (pe_match) begin
            qcnt_r[pe_cpu] <= qcnt_r[pe_cpu] + CW'(1);
          end else begin
            k_r <= k_r + CW'(1);
          end
        end
      end

      if (cmd.scan_fin) begin
        pcnt_r <= k_r;
      end

      if (cmd.run_wb) begin
        rep_run_r[c_r] <= has_job;
        rep_job_r[c_r] <= has_job ? qe.job_id : 8'd0;
        rep_fin_r[c_r] <= fin_c;
        if (has_job) begin
          if (fin_c) begin
            qhead_r[c_r] <= head_nxt;
            qcnt_r[c_r]  <= cur_cnt - CW'(1);
            slice_r[c_r] <= eff_q;
            if (job_total_r != '0) job_total_r <= job_total_r - CW'(1);
          end else if (rot_c) begin
            qhead_r[c_r] <= head_nxt;
            slice_r[c_r] <= eff_q;
          end else begin
            slice_r[c_r] <= sl_dec;
          end
        end
        c_r <= c_r + CIW'(1);
      end

      if (cmd.emit_sub) begin
        out_data_r <= '{status: sub_status_r, cpu_index: 2'd0, running: 1'b0,
                        run_job: 8'd0, finished: 1'b0, tick_time: time_r,
                        all_done: (job_total_r == '0), last: 1'b1};
      end else if (cmd.emit_tick) begin
        out_data_r <= '{status: ST_TICK, cpu_index: 2'(e_r), running: rep_run_r[e_r],
                        run_job: rep_job_r[e_r], finished: rep_fin_r[e_r],
                        tick_time: time_r, all_done: (job_total_r == '0),
                        last: sts.emit_last};
        e_r <= e_r + CIW'(1);
      end

      if (cmd.emit_sub || cmd.emit_tick) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.tick_end) begin
        time_r <= time_r + 16'd1;
      end
    end
  end

  assign sts.scan_busy = (rd_idx_r < pcnt_r) || eval_v_r;
  assign sts.run_last  = (3'(c_r) == n_last);
  assign sts.emit_last = (3'(e_r) == n_last);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ sv/affinity_round_robin_scheduler_unit.sv @@
// Affinity round-robin scheduler: one run queue and time slice per CPU.
//
// Input words (in_valid/in_ready) either submit a job to the pending list or
// advance time by one tick. A submit gives one result word with its status.
// A tick moves arriving jobs to their CPU queues, runs each active CPU's head
// job for one unit, then gives one report word per active CPU in CPU order;
// the final word of each input carries last.
// Config writes (cfg_valid/cfg_ready, always ready) set the CPU count and
// the per-CPU time slices; write them only while the block is idle.
// Flow: one input word at a time. A submit writes the pending list, then
// loads the result register. A tick scans the pending entries (one per
// cycle via the pending RAM read port), reads and writes back each active
// CPU's queue head, then gives one report word per cycle while not stalled.
// A stalled out_ready holds the result register and the sequencer waits;
// a new input word is taken while the last result is still held.
// Reset (rst_n, synchronous) empties the pending list and queues, sets time
// to one and restores the config reset values; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module affinity_round_robin_scheduler_unit import arrs_pkg::*; #(
  parameter int NUM_CPUS = 4,
  parameter int MAX_JOBS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_word_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  arrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  arrs_dp #(.NUM_CPUS(NUM_CPUS), .MAX_JOBS(MAX_JOBS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one word in flight: no new word right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous word still in work");

  // a submit result is always the only result of its word
  a_submit_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_TICK |-> out_data.last)
    else $error("submit result without last");

  // with nothing left, a job that ran must have finished
  a_done_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_TICK && out_data.all_done
      |-> !out_data.running || out_data.finished)
    else $error("all_done while a job is still queued");

endmodule

`default_nettype wire
